[design/ars_pkg.sv]
package ars_pkg;

  localparam int unsigned ADDR_W = 64;

  typedef logic [ADDR_W-1:0] addr_t;

  // Command codes carried on cmd_i
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Outcome of one pass through the shared compare unit
  typedef struct packed {
    logic overlap;  // entry intersects the key range
    logic low_lt;   // entry low below merged low
    logic high_gt;  // entry high above merged high
  } cmp_res_t;

endpackage

[design/ars_store.sv]
module ars_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output ars_pkg::addr_t      rd_low_o,
  output ars_pkg::addr_t      rd_high_o,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  ars_pkg::addr_t      wr_low_i,
  input  ars_pkg::addr_t      wr_high_i
);
  import ars_pkg::*;

  addr_t mem_low  [DEPTH];
  addr_t mem_high [DEPTH];
  addr_t rd_low_q;
  addr_t rd_high_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_low[wr_addr_i]  <= wr_low_i;
      mem_high[wr_addr_i] <= wr_high_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_low_q  <= mem_low[rd_addr_i];
      rd_high_q <= mem_high[rd_addr_i];
    end
  end

  assign rd_low_o  = rd_low_q;
  assign rd_high_o = rd_high_q;

endmodule

[design/ars_cmp.sv]
module ars_cmp (
  input  ars_pkg::addr_t   ent_low_i,
  input  ars_pkg::addr_t   ent_high_i,
  input  ars_pkg::addr_t   key_low_i,
  input  ars_pkg::addr_t   key_high_i,
  input  ars_pkg::addr_t   acc_low_i,
  input  ars_pkg::addr_t   acc_high_i,
  output ars_pkg::cmp_res_t res_o
);
  import ars_pkg::*;

  // Inclusive ranges intersect when each starts no later than the other ends
  always_comb begin
    res_o.overlap = (ent_low_i <= key_high_i) && (ent_high_i >= key_low_i);
    res_o.low_lt  = ent_low_i < acc_low_i;
    res_o.high_gt = ent_high_i > acc_high_i;
  end

endmodule

[design/address_range_set.sv]
// Channel   Ports                                               Dir  Beat when
// command   start_i, busy_o, cmd_i, base_address_i,             in   start_i && !busy_o
//           range_size_i, query_address_i
// result    done_o, contained_o, table_full_o                   out  done_o (one cycle)
//
// An insert of size zero returns its result in the cycle after the
// beat. Every other item sweeps the entry table through one shared compare
// unit, one entry per cycle, behind a memory with a registered read port:
// busy_o stays high until the sweep is done, and the result strobe comes
// as busy_o drops; the table walk sets how long busy_o stays high.
// Reset clears the sequencer, the outputs and all entry valid bits at once;
// the entry bounds are not reset and count only once their valid bit is set.
// The receiver cannot stall: a result is shown for exactly one cycle.
module address_range_set #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic           cmd_i,
  input  ars_pkg::addr_t base_address_i,
  input  ars_pkg::addr_t range_size_i,
  input  ars_pkg::addr_t query_address_i,
  output logic           done_o,
  output logic           contained_o,
  output logic           table_full_o
);
  import ars_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Sequencer and control registers
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_done_q, rd_done_d;
  logic              ev_pend_q, ev_pend_d;
  logic [IDX_W-1:0]  ev_idx_q, ev_idx_d;
  logic              hit_q, hit_d;
  logic              slot_ok_q, slot_ok_d;
  logic              free_ok_q, free_ok_d;
  logic [MAX_RANGES-1:0] valid_q, valid_d;
  logic              done_q, done_d;
  logic              contained_q, contained_d;
  logic              full_q, full_d;

  // Payload registers
  logic              cmd_q, cmd_d;
  addr_t             key_low_q, key_low_d;
  addr_t             key_high_q, key_high_d;
  addr_t             acc_low_q, acc_low_d;
  addr_t             acc_high_q, acc_high_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  free_q, free_d;

  logic              accept;
  addr_t             size_m1;
  addr_t             stop_addr;
  logic              rd_en;
  addr_t             ent_low;
  addr_t             ent_high;
  cmp_res_t          cmp_res;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;

  assign accept = start_i && !busy_o;

  // Last address of an insert, saturated at all ones
  assign size_m1   = range_size_i - addr_t'(1);
  assign stop_addr = (size_m1 > ~base_address_i) ? '1 : base_address_i + size_m1;

  assign rd_en   = (state_q == ST_SCAN) && !rd_done_q;
  assign we      = (state_q == ST_FIN) && (cmd_q == CMD_INSERT) && (slot_ok_q || free_ok_q);
  assign wr_addr = slot_ok_q ? slot_q : free_q;

  ars_store #(
    .DEPTH (MAX_RANGES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_low_o  (ent_low),
    .rd_high_o (ent_high),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_low_i  (acc_low_q),
    .wr_high_i (acc_high_q)
  );

  ars_cmp u_cmp (
    .ent_low_i  (ent_low),
    .ent_high_i (ent_high),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .acc_low_i  (acc_low_q),
    .acc_high_i (acc_high_q),
    .res_o      (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    rd_done_d   = rd_done_q;
    ev_pend_d   = 1'b0;
    ev_idx_d    = ev_idx_q;
    hit_d       = hit_q;
    slot_ok_d   = slot_ok_q;
    free_ok_d   = free_ok_q;
    valid_d     = valid_q;
    done_d      = 1'b0;
    contained_d = contained_q;
    full_d      = full_q;
    cmd_d       = cmd_q;
    key_low_d   = key_low_q;
    key_high_d  = key_high_q;
    acc_low_d   = acc_low_q;
    acc_high_d  = acc_high_q;
    slot_d      = slot_q;
    free_d      = free_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i;
          rd_idx_d  = '0;
          rd_done_d = 1'b0;
          hit_d     = 1'b0;
          slot_ok_d = 1'b0;
          free_ok_d = 1'b0;
          if (cmd_i == CMD_QUERY) begin
            key_low_d  = query_address_i;
            key_high_d = query_address_i;
            state_d    = ST_SCAN;
          end else if (range_size_i == '0) begin
            // Empty insert: answer at once, table untouched
            done_d      = 1'b1;
            contained_d = 1'b0;
            full_d      = 1'b0;
          end else begin
            key_low_d  = base_address_i;
            key_high_d = stop_addr;
            acc_low_d  = base_address_i;
            acc_high_d = stop_addr;
            state_d    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read; the data of the last read is evaluated now
        if (!rd_done_q) begin
          ev_pend_d = 1'b1;
          ev_idx_d  = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            rd_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end
        if (ev_pend_q) begin
          if (valid_q[ev_idx_q]) begin
            if (cmp_res.overlap) begin
              hit_d = 1'b1;
              if (cmd_q == CMD_INSERT) begin
                // Fold the entry into the merged range and drop it
                if (cmp_res.low_lt) begin
                  acc_low_d = ent_low;
                end
                if (cmp_res.high_gt) begin
                  acc_high_d = ent_high;
                end
                valid_d[ev_idx_q] = 1'b0;
                if (!slot_ok_q) begin
                  slot_ok_d = 1'b1;
                  slot_d    = ev_idx_q;
                end
              end
            end
          end else if (!free_ok_q) begin
            free_ok_d = 1'b1;
            free_d    = ev_idx_q;
          end
          if (rd_done_q) begin
            state_d = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_QUERY) begin
          contained_d = hit_q;
          full_d      = 1'b0;
        end else begin
          contained_d = 1'b0;
          full_d      = !(slot_ok_q || free_ok_q);
          if (we) begin
            valid_d[wr_addr] = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      rd_done_q   <= 1'b0;
      ev_pend_q   <= 1'b0;
      ev_idx_q    <= '0;
      hit_q       <= 1'b0;
      slot_ok_q   <= 1'b0;
      free_ok_q   <= 1'b0;
      valid_q     <= '0;
      done_q      <= 1'b0;
      contained_q <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      rd_done_q   <= rd_done_d;
      ev_pend_q   <= ev_pend_d;
      ev_idx_q    <= ev_idx_d;
      hit_q       <= hit_d;
      slot_ok_q   <= slot_ok_d;
      free_ok_q   <= free_ok_d;
      valid_q     <= valid_d;
      done_q      <= done_d;
      contained_q <= contained_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_low_q  <= key_low_d;
    key_high_q <= key_high_d;
    acc_low_q  <= acc_low_d;
    acc_high_q <= acc_high_d;
    slot_q     <= slot_d;
    free_q     <= free_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign contained_o  = contained_q;
  assign table_full_o = full_q;

endmodule

[design/ars_chk.sv]
module ars_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           cmd_i,
  input ars_pkg::addr_t range_size_i,
  input logic           done_o,
  input logic           contained_o,
  input logic           table_full_o
);
  import ars_pkg::*;

  // Result beat only shows once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  // A result beat never sets both contained_o and table_full_o
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(contained_o && table_full_o))
    else $error("contained and table_full both set");

  // A query beat starts a table sweep
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_QUERY) |=> (busy_o && !done_o))
    else $error("query did not start a sweep");

  // An empty insert answers next cycle with both flags clear
  a_zero_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == CMD_INSERT && range_size_i == '0)
      |=> (done_o && !busy_o && !contained_o && !table_full_o))
    else $error("empty insert result wrong");

endmodule

bind address_range_set ars_chk u_ars_chk (.*);

[dv/address_range_set_test.sv]
module address_range_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ars_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned RAND_BEATS  = 1750;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Each random window spans 4 KiB of bases plus up to 1 KiB of length.
  localparam addr_t       WIN_SPAN    = 64'd5120;
  localparam addr_t       ALL_ONES    = '1;

  // One answer per beat: membership flag and dropped-insert flag.
  typedef struct packed {
    logic hit;
    logic full;
  } answer_t;

  // Row of the directed table. When known is set, the answer typed in the
  // row is what the block must return; otherwise the shadow table decides.
  typedef struct {
    logic  cmd;
    addr_t base;
    addr_t size;
    addr_t qaddr;
    bit    known;
    logic  hit;
    logic  full;
  } probe_t;

  logic  clk_i;
  logic  rst_ni          = 1'b0;
  logic  start_i         = 1'b0;
  logic  cmd_i           = CMD_INSERT;
  addr_t base_address_i  = '0;
  addr_t range_size_i    = '0;
  addr_t query_address_i = '0;
  logic  busy_o;
  logic  done_o;
  logic  contained_o;
  logic  table_full_o;

  // Shadow copy of the range table, updated at every accepted beat.
  logic    shadow_valid [SLOTS];
  addr_t   shadow_lo    [SLOTS];
  addr_t   shadow_hi    [SLOTS];

  answer_t     answers_due [$];
  answer_t     oldest;
  int          errors    = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 9;

  address_range_set #(
    .MAX_RANGES(SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .base_address_i (base_address_i),
    .range_size_i   (range_size_i),
    .query_address_i(query_address_i),
    .done_o         (done_o),
    .contained_o    (contained_o),
    .table_full_o   (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold reset low, then release it once for the whole run.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Fold [first, first+len-1] into the shadow table. The last address
  // saturates at all ones; every overlapping entry, fully covered ones
  // included, is cleared and the union lands in the lowest freed slot.
  // Touching ranges stay apart. Return 1 when the insert is dropped.
  function automatic logic fold_range(input addr_t first, input addr_t len);
    addr_t last;
    addr_t lo;
    addr_t hi;
    int    slot = -1;
    if (len == '0)
      return 1'b0;
    last = (len - addr_t'(1) > ~first) ? ALL_ONES : first + (len - addr_t'(1));
    lo   = first;
    hi   = last;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_lo[i] <= last && shadow_hi[i] >= first) begin
        if (shadow_lo[i] < lo) lo = shadow_lo[i];
        if (shadow_hi[i] > hi) hi = shadow_hi[i];
        shadow_valid[i] = 1'b0;
        if (slot < 0) slot = i;
      end
    end
    // No overlap: take the lowest free slot, if any is left.
    if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!shadow_valid[i] && slot < 0) slot = i;
      end
    end
    if (slot < 0)
      return 1'b1;
    shadow_valid[slot] = 1'b1;
    shadow_lo[slot]    = lo;
    shadow_hi[slot]    = hi;
    return 1'b0;
  endfunction

  function automatic logic range_hit(input addr_t addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_lo[i] <= addr && addr <= shadow_hi[i])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Present one command, hold it until the block takes it, then queue the
  // answer it must produce. An idle stretch of random length may come first,
  // so gaps land anywhere within the table walk of the previous command.
  task automatic send_beat(input logic cmd, input addr_t base, input addr_t size,
                           input addr_t qaddr, input bit known,
                           input logic want_hit, input logic want_full);
    answer_t ans;
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 24)) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    base_address_i  <= base;
    range_size_i    <= size;
    query_address_i <= qaddr;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    // Beat taken at this edge: advance the shadow table.
    ans = '0;
    if (cmd == CMD_QUERY)
      ans.hit = range_hit(qaddr);
    else
      ans.full = fold_range(base, size);
    if (known) begin
      ans.hit  = want_hit;
      ans.full = want_full;
    end
    answers_due.push_back(ans);
  endtask

  // Compare every strobed result with the oldest answer still owed.
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: contained=%b table_full=%b",
                 $time, contained_o, table_full_o);
      end else begin
        oldest = answers_due.pop_front();
        if (done_o !== 1'b1 || contained_o !== oldest.hit) begin
          errors++;
          $display("%0t: contained expected %b actual %b (done %b)",
                   $time, oldest.hit, contained_o, done_o);
        end
        if (table_full_o !== oldest.full) begin
          errors++;
          $display("%0t: table_full expected %b actual %b",
                   $time, oldest.full, table_full_o);
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    probe_t      probes [$];
    addr_t       win_base;
    addr_t       base;
    addr_t       size;
    addr_t       qaddr;
    logic        cmd;
    int unsigned epoch_left;
    int unsigned roll;
    int unsigned slot;

    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_lo[i]    = '0;
      shadow_hi[i]    = '0;
    end

    // Directed table. Empty table first, then zero size, saturation at the
    // top, an exact fit up to all ones, touching neighbors, a merge that
    // swallows a fully covered middle range, an already covered insert,
    // and finally a full table that drops a fresh range.
    probes.push_back('{CMD_QUERY,  '0, '0, '0, 1'b1, 1'b0, 1'b0});
    probes.push_back('{CMD_QUERY,  '0, '0, ALL_ONES, 1'b1, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, '0, '0, '0, 1'b1, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, ALL_ONES, ALL_ONES, '0, 1'b1, 1'b0, 1'b0});
    probes.push_back('{CMD_QUERY,  '0, '0, ALL_ONES, 1'b1, 1'b1, 1'b0});
    probes.push_back('{CMD_INSERT, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h0, 64'h1, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h1, 64'h1, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h100, 64'h10, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h120, 64'h10, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h140, 64'h10, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h108, 64'h41, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_QUERY,  '0, '0, 64'h130, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'h110, 64'h4, '0, 1'b0, 1'b0, 1'b0});
    // Four entries stand now; twelve disjoint ones fill the table.
    for (int k = 1; k <= 12; k++)
      probes.push_back('{CMD_INSERT, addr_t'(k) << 12, 64'h10, '0, 1'b0, 1'b0, 1'b0});
    probes.push_back('{CMD_INSERT, 64'hF000_0000, 64'h1, '0, 1'b1, 1'b0, 1'b1});
    probes.push_back('{CMD_QUERY,  '0, '0, 64'hF000_0000, 1'b1, 1'b0, 1'b0});

    while (rst_ni !== 1'b1) @(posedge clk_i);
    @(posedge clk_i);

    foreach (probes[i])
      send_beat(probes[i].cmd, probes[i].base, probes[i].size, probes[i].qaddr,
                probes[i].known, probes[i].hit, probes[i].full);

    // Random part. Inserts mostly fall in a 4 KiB window so that ranges
    // overlap, touch and merge; each epoch ends with one insert spanning
    // everything from address zero up through the window, which folds all
    // entries up to there into one, and the window then moves up. A small
    // share goes to the top of the space (saturation), to zero sizes and to
    // scattered bases. Queries aim at entry edges, the window, the top of
    // the space or anywhere. Ignored fields carry random values.
    win_base   = 64'h1_0000;
    epoch_left = 0;
    for (int n = 0; n < RAND_BEATS; n++) begin
      idle_pct = (n < RAND_BEATS / 3) ? 9 : (n < 2 * RAND_BEATS / 3) ? 50 : 0;
      if (epoch_left == 0) begin
        send_beat(CMD_INSERT, '0, win_base + WIN_SPAN, {$urandom, $urandom},
                  1'b0, 1'b0, 1'b0);
        win_base  += WIN_SPAN + addr_t'($urandom_range(0, 256));
        epoch_left = $urandom_range(40, 80);
      end else begin
        epoch_left--;
        cmd   = ($urandom_range(99) < 40) ? CMD_QUERY : CMD_INSERT;
        base  = {$urandom, $urandom};
        size  = {$urandom, $urandom};
        qaddr = {$urandom, $urandom};
        roll  = $urandom_range(999);
        if (cmd == CMD_QUERY) begin
          if (roll < 500) begin
            slot = $urandom_range(SLOTS - 1);
            if (shadow_valid[slot]) begin
              case ($urandom_range(3))
                0:       qaddr = shadow_lo[slot] - addr_t'(1);
                1:       qaddr = shadow_lo[slot];
                2:       qaddr = shadow_hi[slot];
                default: qaddr = shadow_hi[slot] + addr_t'(1);
              endcase
            end else begin
              qaddr = win_base + addr_t'($urandom_range(5119));
            end
          end else if (roll < 800) begin
            qaddr = win_base + addr_t'($urandom_range(5119));
          end else if (roll < 900) begin
            qaddr = ALL_ONES - addr_t'($urandom_range(4095));
          end
        end else begin
          if (roll < 5) begin
            size = addr_t'($urandom_range(1, 64));
          end else if (roll < 55) begin
            size = '0;
          end else if (roll < 105) begin
            base = ALL_ONES - addr_t'($urandom_range(4095));
            size = addr_t'($urandom_range(1, 256));
          end else if (roll < 155) begin
            base = ALL_ONES - addr_t'($urandom_range(4095));
          end else begin
            base = win_base + addr_t'($urandom_range(4095));
            size = ($urandom_range(4) == 0) ? addr_t'($urandom_range(65, 1024))
                                            : addr_t'($urandom_range(1, 64));
          end
        end
        send_beat(cmd, base, size, qaddr, 1'b0, 1'b0, 1'b0);
      end
    end

    // Drop start, drain what is owed, then watch for stray strobes.
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
design/ars_pkg.sv
design/ars_store.sv
design/ars_cmp.sv
design/address_range_set.sv
design/ars_chk.sv
dv/address_range_set_test.sv
